/* design/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned BUF_DEPTH = 2;
  localparam int unsigned BUF_PTR_W = $clog2(BUF_DEPTH);
  localparam int unsigned BUF_CNT_W = $clog2(BUF_DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
    logic        [PRIO_W-1:0]   prio;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic        [PRIO_W-1:0]   prio;
    logic                       empty;
    logic        [COUNT_W-1:0]  count;
    logic                       error;
  } res_t;

endpackage

/* design/spq_front.sv */
// Front end: accepts request beats, classifies them and buffers them for the cell array.
module spq_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        req_type,
  input  logic signed [spq_pkg::VALUE_W-1:0] item_value,
  input  logic        [spq_pkg::PRIO_W-1:0]  item_priority,
  output logic                        cmd_valid,
  output spq_pkg::cmd_t               cmd,
  input  logic                        cmd_take
);
  import spq_pkg::*;

  cmd_t                 buf_mem [BUF_DEPTH];
  logic [BUF_PTR_W-1:0] wr_ptr;
  logic [BUF_PTR_W-1:0] rd_ptr;
  logic [BUF_CNT_W-1:0] fill;
  cmd_t                 cmd_in;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    cmd_in.op    = req_type ? OP_DELETE : OP_INSERT;
    cmd_in.value = item_value;
    cmd_in.prio  = item_priority;
    full      = (fill == BUF_CNT_W'(BUF_DEPTH));
    cmd_valid = (fill != '0);
    cmd       = buf_mem[rd_ptr];
    do_push   = push && !full;
    do_pop    = cmd_take && cmd_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

/* design/spq_back.sv */
// Back end: sorted shifting cell array; one command a cycle while the result buffer has room.
module spq_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  spq_pkg::cmd_t cmd,
  output logic          cmd_take,
  input  logic          res_space,
  output logic          res_push,
  output spq_pkg::res_t res
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [VALUE_W-1:0] slot_value      [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] slot_value_next [QUEUE_DEPTH];
  logic        [PRIO_W-1:0]  slot_prio       [QUEUE_DEPTH];
  logic        [PRIO_W-1:0]  slot_prio_next  [QUEUE_DEPTH];
  logic        [CNT_W-1:0]   count;
  logic        [CNT_W-1:0]   count_next;
  logic [QUEUE_DEPTH-1:0]    ge;
  logic                      fire;
  logic                      err;

  always_comb begin
    fire = cmd_valid && res_space;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count) && (slot_prio[i] >= cmd.prio);
      slot_value_next[i] = slot_value[i];
      slot_prio_next[i]  = slot_prio[i];
    end
    count_next = count;
    err        = 1'b0;
    if (fire) begin
      case (cmd.op)
        OP_INSERT: begin
          if (count == CNT_W'(QUEUE_DEPTH)) begin
            err = 1'b1;
          end else begin
            count_next = count + 1'b1;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (!ge[i]) begin
                if (i == 0) begin
                  slot_value_next[i] = cmd.value;
                  slot_prio_next[i]  = cmd.prio;
                end else if (ge[i-1]) begin
                  slot_value_next[i] = cmd.value;
                  slot_prio_next[i]  = cmd.prio;
                end else begin
                  slot_value_next[i] = slot_value[i-1];
                  slot_prio_next[i]  = slot_prio[i-1];
                end
              end
            end
          end
        end
        OP_DELETE: begin
          if (count == '0) begin
            err = 1'b1;
          end else begin
            count_next = count - 1'b1;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              slot_value_next[i] = slot_value[i+1];
              slot_prio_next[i]  = slot_prio[i+1];
            end
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
    cmd_take  = fire;
    res_push  = fire;
    res.empty = (count_next == '0);
    res.value = res.empty ? '0 : slot_value_next[0];
    res.prio  = res.empty ? '0 : slot_prio_next[0];
    res.count = COUNT_W'(count_next);
    res.error = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_value[i] <= slot_value_next[i];
      slot_prio[i]  <= slot_prio_next[i];
    end
  end

endmodule

/* design/spq_result_queue.sv */
// Result buffer: holds finished result beats until the consumer pops them.
module spq_result_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_push,
  input  spq_pkg::res_t res,
  output logic          res_space,
  input  logic          pop,
  output logic          empty,
  output spq_pkg::res_t res_out
);
  import spq_pkg::*;

  res_t                 buf_mem [BUF_DEPTH];
  logic [BUF_PTR_W-1:0] wr_ptr;
  logic [BUF_PTR_W-1:0] rd_ptr;
  logic [BUF_CNT_W-1:0] fill;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    res_space = (fill != BUF_CNT_W'(BUF_DEPTH));
    empty     = (fill == '0);
    res_out   = buf_mem[rd_ptr];
    do_push   = res_push && res_space;
    do_pop    = pop && !empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_mem[wr_ptr] <= res;
    end
  end

endmodule

/* design/sorted_priority_queue_unit.sv */
// Top level of the sorted priority queue: front buffer, cell array and result buffer.
//
//   Channel   Handshake     Payload
//   request   push / full   req_type, item_value, item_priority
//   result    pop / empty   head_value, head_priority, is_empty, entry_count, op_error
//
// One request beat is taken per cycle while full is low; each yields one result beat.
// A request beat is first written into the request buffer; when the cell array
// takes it from there, the shifting cells update and the result buffer
// captures the outcome at the same edge as the cells.
// Reset is synchronous and clears the entry count and both buffers; the
// cells hold no reset value and need no clearing pass.
// A stalled result side fills the result buffer, then the request buffer,
// and only then raises full.
module sorted_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               req_type,
  input  logic signed [spq_pkg::VALUE_W-1:0] item_value,
  input  logic        [spq_pkg::PRIO_W-1:0]  item_priority,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [spq_pkg::VALUE_W-1:0] head_value,
  output logic        [spq_pkg::PRIO_W-1:0]  head_priority,
  output logic                               is_empty,
  output logic        [spq_pkg::COUNT_W-1:0] entry_count,
  output logic                               op_error
);
  import spq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_space;
  logic res_push;
  res_t res;
  res_t res_out;

  spq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .item_value    (item_value),
    .item_priority (item_priority),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  spq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_space (res_space),
    .res_push  (res_push),
    .res       (res)
  );

  spq_result_queue u_result (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .res_space (res_space),
    .pop       (pop),
    .empty     (empty),
    .res_out   (res_out)
  );

  assign head_value    = res_out.value;
  assign head_priority = res_out.prio;
  assign is_empty      = res_out.empty;
  assign entry_count   = res_out.count;
  assign op_error      = res_out.error;

endmodule
